### rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/mpt_pkg.sv
// Package: widths, register indexes and a reduction helper for the twist block.
package mpt_pkg;
  localparam int WORD_WIDTH = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int BIT_CNT_W  = $clog2(WORD_WIDTH + 1);

  typedef logic [WORD_WIDTH-1:0] word_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWIST   = 1'd1;

  localparam word_t MODULUS_RST = word_t'(12289);
  localparam word_t TWIST_RST   = word_t'(1);
  localparam word_t ONE_W       = word_t'(1);

  // one modular doubling/adding step: (a + b) mod m, a and b below m
  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    word_t gap;
    gap = m - b;
    if (a >= gap) return a - gap;
    return a + b;
  endfunction
endpackage

### rtl/mpt_stream_if.sv
// Valid/ready stream interfaces for the input and result words.
interface mpt_in_if;
  import mpt_pkg::*;
  logic  valid;
  logic  ready;
  word_t coefficient;
  logic  last_in;
  modport source (output valid, coefficient, last_in, input ready);
  modport sink (input valid, coefficient, last_in, output ready);
endinterface

interface mpt_out_if;
  import mpt_pkg::*;
  logic  valid;
  logic  ready;
  word_t scaled;
  logic  last_out;
  modport source (output valid, scaled, last_out, input ready);
  modport sink (input valid, scaled, last_out, output ready);
endinterface

interface mpt_cfg_if;
  import mpt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/mpt_front.sv
// Front end: accepts input words into a two-entry queue.
module mpt_front (
  input  logic         clk,
  input  logic         rst_n,
  mpt_in_if.sink       in_ch,
  output logic         q_valid,
  input  logic         q_pop,
  output mpt_pkg::word_t q_coef,
  output logic         q_last
);
  import mpt_pkg::*;

  word_t      coef_r [2];
  logic [1:0] last_r;
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_coef      = coef_r[rd_ptr_r];
  assign q_last      = last_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      coef_r[wr_ptr_r] <= in_ch.coefficient;
      last_r[wr_ptr_r] <= in_ch.last_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, q_valid)
  `ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
endmodule

### rtl/mpt_back.sv
// Back end: bit-serial modular multiplies per word, then an output register.
module mpt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  mpt_pkg::word_t q_coef,
  input  logic           q_last,
  input  mpt_pkg::word_t modulus,
  input  mpt_pkg::word_t twist,
  mpt_out_if.source      out_ch
);
  import mpt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_POW  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [BIT_CNT_W-1:0] bit_r;
  word_t                pow_r, a_r, b_r, acc_r, res_r, coef_r, tw_r;
  logic                 last_r;
  logic                 out_valid_r;
  word_t                out_data_r;
  logic                 out_last_r;
  word_t                acc_dbl, acc_step;
  logic                 m_zero;
  logic                 pow_below;
  word_t                one_m;
  logic [BIT_CNT_W-1:0] bit_idx;

  assign m_zero    = (modulus == '0);
  assign pow_below = (pow_r < modulus);
  // 1 mod m for a nonzero modulus
  assign one_m     = (modulus == ONE_W) ? '0 : ONE_W;
  assign bit_idx   = bit_r - BIT_CNT_W'(1);
  assign acc_dbl   = add_mod(acc_r, acc_r, modulus);
  assign acc_step  = b_r[bit_idx[$clog2(WORD_WIDTH)-1:0]] ?
                     add_mod(acc_dbl, a_r, modulus) : acc_dbl;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.scaled   = out_data_r;
  assign out_ch.last_out = out_last_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_RED;
      S_RED:  state_nxt = m_zero ? S_OUT : (pow_below ? S_MUL1 : S_POW);
      S_POW:  if (bit_r == BIT_CNT_W'(1)) state_nxt = S_MUL1;
      S_MUL1: if (bit_r == BIT_CNT_W'(1)) state_nxt = S_MUL2;
      S_MUL2: if (bit_r == BIT_CNT_W'(1)) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pow_r       <= ONE_W;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        pow_r <= last_r ? ONE_W : (m_zero ? '0 : acc_r);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: shift-add over the bits of b_r with a_r below the modulus;
  // a stale power not below the modulus gets one reduction pass first
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        coef_r <= q_coef;
        last_r <= q_last;
        tw_r   <= twist;
      end
      S_RED: begin
        acc_r <= '0;
        bit_r <= BIT_CNT_W'(WORD_WIDTH);
        if (pow_below) begin
          a_r <= pow_r;
          b_r <= coef_r;
        end else begin
          a_r <= one_m;
          b_r <= pow_r;
        end
      end
      S_POW: begin
        if (bit_r == BIT_CNT_W'(1)) begin
          a_r   <= acc_step;
          b_r   <= coef_r;
          acc_r <= '0;
          bit_r <= BIT_CNT_W'(WORD_WIDTH);
        end else begin
          acc_r <= acc_step;
          bit_r <= bit_r - BIT_CNT_W'(1);
        end
      end
      S_MUL1: begin
        if (bit_r == BIT_CNT_W'(1)) begin
          res_r <= acc_step;
          b_r   <= tw_r;
          acc_r <= '0;
          bit_r <= BIT_CNT_W'(WORD_WIDTH);
        end else begin
          acc_r <= acc_step;
          bit_r <= bit_r - BIT_CNT_W'(1);
        end
      end
      S_MUL2: begin
        acc_r <= acc_step;
        bit_r <= bit_r - BIT_CNT_W'(1);
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_r <= m_zero ? '0 : res_r;
          out_last_r <= last_r;
        end
      end
      default: ;
    endcase
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop, state_r == S_IDLE)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready,
               out_valid_r && $stable(out_data_r))
endmodule

### rtl/modular_power_twist_top.sv
// Top level: configuration registers, front queue and back multiply engine.
// Usage:
//   in_ch carries one coefficient word per handshake (valid && ready) with a
//   last_in flag closing each vector. out_ch returns scaled and last_out in the
//   same order, one result per input word. cfg_ch writes register 0 (modulus)
//   or register 1 (twist factor); write it only while the block is idle.
// Path: each accepted word passes the front queue, a setup state, two
//   bit-serial modular multiplies of WORD_WIDTH steps each and the output
//   register. When the running power is not below the modulus (modulus
//   lowered mid-vector, or a modulus of one) a reduction pass runs first.
//   A zero modulus skips the reduction pass and the multiplies.
// The back end finishes each word before it pops the next one.
// A two-word front queue keeps accepting while the back end computes.
// Reset: modulus 12289, twist factor 1, running power 1, queue empty.
// A stalled receiver holds the result register; the back end waits and the
// queue fills, then in_ch.ready drops.
module modular_power_twist_top (
  input logic      clk,
  input logic      rst_n,
  mpt_in_if.sink   in_ch,
  mpt_out_if.source out_ch,
  mpt_cfg_if.sink  cfg_ch
);
  import mpt_pkg::*;

  word_t modulus_r, twist_r;
  logic  q_valid, q_pop, q_last;
  word_t q_coef;

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      twist_r   <= TWIST_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MODULUS: modulus_r <= cfg_ch.data;
        REG_TWIST:   twist_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  mpt_front u_front (
    .clk, .rst_n, .in_ch,
    .q_valid, .q_pop, .q_coef, .q_last
  );

  mpt_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_coef, .q_last,
    .modulus(modulus_r), .twist(twist_r), .out_ch
  );
endmodule
